/* hw/rtl/same_size_2d_convolution_defines.svh */
// ---------------------------------------------------------------------------
// same_size_2d_convolution assertion macros
// Clocked assertion helpers shared by the convolution RTL
// ---------------------------------------------------------------------------
`ifndef SAME_SIZE_2D_CONVOLUTION_DEFINES_SVH
`define SAME_SIZE_2D_CONVOLUTION_DEFINES_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SCC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define SCC_ASSERT(lbl, prop)
`define SCC_NEVER(lbl, expr)
`endif
`endif

/* hw/rtl/scc_pkg.sv */
// ---------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the convolution cells and top level
// ---------------------------------------------------------------------------
package scc_pkg;

  localparam int ACC_W  = 48;
  localparam int P_CW   = 13;
  localparam int P_RW   = 14;
  localparam int P_HW   = 13;
  localparam int P_BW   = 6;

  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KROWS  = 3'd2;
  localparam logic [2:0] REG_KCOLS  = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;

  typedef struct packed {
    logic              pix_en;
    logic [P_BW-1:0]   bank;
    logic [P_CW-1:0]   pcol;
    logic signed [23:0] pixel;
    logic              k_en;
    logic [7:0]        kaddr;
    logic signed [15:0] kval;
  } wr_t;

  typedef struct packed {
    logic              step_en;
    logic              clear;
    logic              shift;
    logic [P_CW-1:0]   col;
    logic              col_ok;
    logic [3:0]        b;
    logic [P_BW-1:0]   base;
    logic [P_RW-1:0]   row_ref;
    logic [4:0]        kr;
    logic [P_HW-1:0]   h;
  } ctl_t;

endpackage

/* hw/rtl/same_size_2d_convolution.sv */
// ---------------------------------------------------------------------------
// same_size_2d_convolution
// Zero-padded same-size 2D convolution over a raster pixel stream
// ---------------------------------------------------------------------------
// Input items arrive on s_axis; tuser carries the operation (load coefficient,
// pixel, drain). Results leave on m_axis, tlast on the last output of a frame.
// Geometry and threshold are set through the cfg write port while idle; a
// geometry write restarts the frame.
// One input item is taken at a time. A coefficient load is written while idle;
// an item that yields no result passes through the check state only. For an
// item that yields a result, one kernel column per cycle is stepped through
// the row of cells (one cell per kernel row, each with its own line bank and
// kernel copy), the pipeline is flushed, then the partial sums are shifted
// out along the cell chain into the final adder, one cell per cycle.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block only stalls if a second result is ready
// before the first is taken. Reset clears all position counters and the
// output register; line and kernel stores are not cleared.
// ---------------------------------------------------------------------------
`include "same_size_2d_convolution_defines.svh"

module same_size_2d_convolution import scc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coef_index, coef_value, pixel
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_value
  output logic        m_axis_tlast,   // out_last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int WW    = $clog2(MAX_WIDTH) + 1;
  localparam int HW    = $clog2(MAX_HEIGHT) + 1;
  localparam int KCAP  = (MAX_KERNEL < 16) ? MAX_KERNEL : 16;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MAC, ST_FLUSH, ST_REDUCE, ST_SAT
  } state_t;

  state_t state;

  logic [10:0] frame_width, frame_height;
  logic [4:0]  kernel_rows, kernel_cols;
  logic [30:0] zero_threshold;

  logic [WW-1:0] w, in_col, out_col;
  logic [HW-1:0] h, in_row, out_row;
  logic [P_BW-1:0] in_bank, out_rb;
  logic [4:0] cap_r, cap_c, kr, kc;
  logic [3:0] hr, hc;
  logic [5:0] cnt;
  logic signed [ACC_W-1:0] total;
  logic signed [ACC_W-1:0] acc_chain [MAX_KERNEL+1];

  logic [HW:0] row_ref, lr;
  logic [WW:0] col_ref, lc, col_sum;
  logic [P_BW:0] base_sum;
  logic ready_res, accept, last;
  op_t op;
  wr_t wr;
  ctl_t ctl;

  logic signed [ACC_W-1:0] sh;
  logic [31:0] sat_v;
  logic [32:0] mag;
  logic [31:0] res_v;

  // geometry in use
  always_comb begin
    w = (frame_width < 11'd2) ? WW'(2) :
        (32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
    h = (frame_height < 11'd2) ? HW'(2) :
        (32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);
    cap_r = (32'(h) < KCAP) ? 5'(h) : 5'(KCAP);
    cap_c = (32'(w) < KCAP) ? 5'(w) : 5'(KCAP);
    kr = (kernel_rows < 5'd2) ? 5'd2 : (kernel_rows > cap_r) ? cap_r : kernel_rows;
    kc = (kernel_cols < 5'd2) ? 5'd2 : (kernel_cols > cap_c) ? cap_c : kernel_cols;
    hr = kr[4:1];
    hc = kc[4:1];
  end

  assign op     = op_t'(s_axis_tuser);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    row_ref = (HW+1)'(out_row) + (HW+1)'(hr);
    lr      = (row_ref > (HW+1)'(h - 1'b1)) ? (HW+1)'(h - 1'b1) : row_ref;
    col_ref = (WW+1)'(out_col) + (WW+1)'(hc);
    lc      = (col_ref > (WW+1)'(w - 1'b1)) ? (WW+1)'(w - 1'b1) : col_ref;
    ready_res = ((HW+1)'(in_row) > lr) ||
                (((HW+1)'(in_row) == lr) && ((WW+1)'(in_col) > lc));
    col_sum  = col_ref - (WW+1)'(cnt[3:0]);
    base_sum = (P_BW+1)'(out_rb) + (P_BW+1)'(hr);
    if (base_sum >= (P_BW+1)'(MAX_KERNEL)) begin
      base_sum = base_sum - (P_BW+1)'(MAX_KERNEL);
    end
    last = (out_row == h - 1'b1) && (out_col == w - 1'b1);
  end

  always_comb begin
    wr.pix_en = accept && (op == OP_PIXEL) && (in_row < h);
    wr.bank   = in_bank;
    wr.pcol   = P_CW'(in_col);
    wr.pixel  = s_axis_tdata[47:24];
    wr.k_en   = accept && (op == OP_COEF);
    wr.kaddr  = s_axis_tdata[7:0];
    wr.kval   = s_axis_tdata[23:8];
    ctl.step_en = (state == ST_MAC);
    ctl.clear   = (state == ST_CHECK) && ready_res;
    ctl.shift   = (state == ST_REDUCE);
    ctl.col     = P_CW'(col_sum);
    ctl.col_ok  = (col_ref >= (WW+1)'(cnt[3:0])) && (col_sum < (WW+1)'(w));
    ctl.b       = cnt[3:0];
    ctl.base    = base_sum[P_BW-1:0];
    ctl.row_ref = P_RW'(row_ref);
    ctl.kr      = kr;
    ctl.h       = P_HW'(h);
  end

  assign acc_chain[MAX_KERNEL] = '0;

  for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_cell
    scc_cell #(
      .IDX        (k),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .ctl     (ctl),
      .acc_in  (acc_chain[k+1]),
      .acc_out (acc_chain[k])
    );
  end

  // shift, saturate and clip
  always_comb begin
    sh = total >>> 15;
    if (sh[ACC_W-1:31] == '0 || sh[ACC_W-1:31] == '1) begin
      sat_v = sh[31:0];
    end else if (sh[ACC_W-1]) begin
      sat_v = 32'h8000_0000;
    end else begin
      sat_v = 32'h7FFF_FFFF;
    end
    mag   = sat_v[31] ? (33'd0 - {1'b1, sat_v}) : {1'b0, sat_v};
    res_v = (mag < {2'b00, zero_threshold}) ? 32'd0 : sat_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      frame_width    <= 11'd64;
      frame_height   <= 11'd64;
      kernel_rows    <= 5'd3;
      kernel_cols    <= 5'd3;
      zero_threshold <= '0;
      in_row         <= '0;
      in_col         <= '0;
      in_bank        <= '0;
      out_row        <= '0;
      out_col        <= '0;
      out_rb         <= '0;
      cnt            <= '0;
      total          <= '0;
      m_axis_tvalid  <= 1'b0;
      m_axis_tdata   <= '0;
      m_axis_tlast   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  frame_width    <= cfg_data[10:0];
          REG_HEIGHT: frame_height   <= cfg_data[10:0];
          REG_KROWS:  kernel_rows    <= cfg_data[4:0];
          REG_KCOLS:  kernel_cols    <= cfg_data[4:0];
          REG_THRESH: zero_threshold <= cfg_data;
          default: ;
        endcase
        if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
            cfg_index == REG_KROWS || cfg_index == REG_KCOLS) begin
          in_row  <= '0;
          in_col  <= '0;
          in_bank <= '0;
          out_row <= '0;
          out_col <= '0;
          out_rb  <= '0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (wr.pix_en) begin
              if (in_col == w - 1'b1) begin
                in_col <= '0;
                in_row <= in_row + 1'b1;
                in_bank <= (in_bank == P_BW'(MAX_KERNEL - 1)) ? '0 : in_bank + 1'b1;
              end else begin
                in_col <= in_col + 1'b1;
              end
            end
            if (op == OP_PIXEL || op == OP_DRAIN) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          cnt   <= '0;
          total <= '0;
          state <= ready_res ? ST_MAC : ST_IDLE;
        end
        ST_MAC: begin
          if (cnt == 6'(kc - 1'b1)) begin
            cnt   <= '0;
            state <= ST_FLUSH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (cnt == 6'd1) begin
            cnt   <= '0;
            state <= ST_REDUCE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_REDUCE: begin
          total <= total + acc_chain[0];
          if (cnt == 6'(MAX_KERNEL - 1)) begin
            cnt   <= '0;
            state <= ST_SAT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SAT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_v;
            m_axis_tlast  <= last;
            state         <= ST_IDLE;
            if (last) begin
              in_row  <= '0;
              in_col  <= '0;
              in_bank <= '0;
              out_row <= '0;
              out_col <= '0;
              out_rb  <= '0;
            end else if (out_col == w - 1'b1) begin
              out_col <= '0;
              out_row <= out_row + 1'b1;
              out_rb  <= (out_rb == P_BW'(MAX_KERNEL - 1)) ? '0 : out_rb + 1'b1;
            end else begin
              out_col <= out_col + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SCC_NEVER(a_in_row_range, in_row > h)
  `SCC_NEVER(a_out_pos_range, (out_row >= h) || (out_col >= w))
  `SCC_ASSERT(a_sat_loads, (state == ST_SAT && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
  `SCC_ASSERT(a_mac_needs_ready, (state == ST_MAC) |-> (in_row > out_row || in_row == h || (in_row == out_row && in_col > out_col)))

endmodule

/* hw/rtl/scc_cell.sv */
// ---------------------------------------------------------------------------
// scc_cell
// One kernel-row cell: line bank, kernel copy, multiply and accumulate
// ---------------------------------------------------------------------------
module scc_cell import scc_pkg::*; #(
  parameter int IDX        = 0,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wr_t                     wr,
  input  ctl_t                    ctl,
  input  logic signed [ACC_W-1:0] acc_in,
  output logic signed [ACC_W-1:0] acc_out
);

  localparam int CIX = $clog2(MAX_WIDTH);

  logic signed [23:0] line_mem [MAX_WIDTH];
  logic signed [15:0] kern_mem [256];

  logic [6:0]         d;
  logic [5:0]         a;
  logic [P_RW-1:0]    a_ext;
  logic               row_ok;
  logic [7:0]         kaddr;
  logic signed [23:0] pix_q;
  logic signed [15:0] coef_q;
  logic               ok1;
  logic signed [39:0] prod;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    d = 7'(ctl.base) + 7'(MAX_KERNEL) - 7'(IDX);
    if (d >= 7'(MAX_KERNEL)) begin
      d = d - 7'(MAX_KERNEL);
    end
    a      = d[5:0];
    a_ext  = P_RW'(a);
    row_ok = (a < 6'(ctl.kr)) && (ctl.row_ref >= a_ext) &&
             ((ctl.row_ref - a_ext) < P_RW'(ctl.h));
    kaddr  = {a[3:0], ctl.b};
  end

  always_ff @(posedge clk) begin
    if (wr.pix_en && wr.bank == P_BW'(IDX)) begin
      line_mem[wr.pcol[CIX-1:0]] <= wr.pixel;
    end
    if (wr.k_en) begin
      kern_mem[wr.kaddr] <= wr.kval;
    end
    pix_q  <= line_mem[ctl.col[CIX-1:0]];
    coef_q <= kern_mem[kaddr];
    prod   <= ok1 ? pix_q * coef_q : 40'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok1 <= 1'b0;
      acc <= '0;
    end else begin
      ok1 <= ctl.step_en & row_ok & ctl.col_ok;
      if (ctl.clear) begin
        acc <= '0;
      end else if (ctl.shift) begin
        acc <= acc_in;
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign acc_out = acc;

endmodule
